// ===== design/wsfpe_pkg.sv =====
// ----------------------------------------------------------------------------
// wsfpe_pkg
// Shared constants and types for the WebSocket frame payload extractor.
// ----------------------------------------------------------------------------
package wsfpe_pkg;

	// Width of the payload length counter (16 to 63)
	localparam int LENGTH_BITS = 63;

	localparam int PHASE_W = 3;

	// Parser phases
	localparam logic [PHASE_W-1:0] PH_FIRST = 3'd0;
	localparam logic [PHASE_W-1:0] PH_LEN   = 3'd1;
	localparam logic [PHASE_W-1:0] PH_EXT16 = 3'd2;
	localparam logic [PHASE_W-1:0] PH_EXT64 = 3'd3;
	localparam logic [PHASE_W-1:0] PH_KEY   = 3'd4;
	localparam logic [PHASE_W-1:0] PH_PAY   = 3'd5;
	localparam logic [PHASE_W-1:0] PH_TRAIL = 3'd6;

	// Length byte codes
	localparam logic [6:0] LEN_CODE_EXT16 = 7'd126;
	localparam logic [6:0] LEN_CODE_EXT64 = 7'd127;

	// One result as produced by the parser step
	typedef struct packed {
		logic       emit;
		logic [7:0] payload_byte;
		logic       has_byte;
		logic       end_of_frame;
		logic       status;
	} result_t;

endpackage

// ===== design/wsfpe_parser.sv =====
// ----------------------------------------------------------------------------
// wsfpe_parser
// Frame state and the combinational step for one frame byte.
// ----------------------------------------------------------------------------
module wsfpe_parser (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic [7:0]          frame_byte,
	input  logic                frame_end,
	output wsfpe_pkg::result_t  result
);

	localparam int LB = wsfpe_pkg::LENGTH_BITS;

	logic [wsfpe_pkg::PHASE_W-1:0] phase_q, phase_d;
	logic [LB-1:0]                 rem_q, rem_d;
	logic [2:0]                    hbc_q, hbc_d;
	logic [31:0]                   key_q, key_d;
	logic [1:0]                    midx_q, midx_d;
	logic                          masked_q, masked_d;

	logic                          go_after;
	logic                          after_masked;
	logic [LB-1:0]                 after_len;
	logic [LB-1:0]                 shifted;
	logic [7:0]                    pb;
	logic                          has;

	// Extended length byte, saturating at all ones
	assign shifted = (|rem_q[LB-1 -: 8]) ? {LB{1'b1}} : {rem_q[LB-9:0], frame_byte};

	always_comb begin
		phase_d      = phase_q;
		rem_d        = rem_q;
		hbc_d        = hbc_q;
		key_d        = key_q;
		midx_d       = midx_q;
		masked_d     = masked_q;
		go_after     = 1'b0;
		after_masked = masked_q;
		after_len    = rem_q;
		pb           = 8'd0;
		has          = 1'b0;

		case (phase_q)
			wsfpe_pkg::PH_FIRST: begin
				phase_d = wsfpe_pkg::PH_LEN;
			end
			wsfpe_pkg::PH_LEN: begin
				masked_d     = frame_byte[7];
				after_masked = frame_byte[7];
				rem_d        = '0;
				hbc_d        = 3'd0;
				if (frame_byte[6:0] == wsfpe_pkg::LEN_CODE_EXT16) begin
					phase_d = wsfpe_pkg::PH_EXT16;
				end else if (frame_byte[6:0] == wsfpe_pkg::LEN_CODE_EXT64) begin
					phase_d = wsfpe_pkg::PH_EXT64;
				end else begin
					go_after  = 1'b1;
					after_len = {{(LB-7){1'b0}}, frame_byte[6:0]};
				end
			end
			wsfpe_pkg::PH_EXT16, wsfpe_pkg::PH_EXT64: begin
				rem_d = shifted;
				if ((phase_q == wsfpe_pkg::PH_EXT16 && hbc_q >= 3'd1) ||
				    (phase_q == wsfpe_pkg::PH_EXT64 && hbc_q == 3'd7)) begin
					go_after  = 1'b1;
					after_len = shifted;
				end else begin
					hbc_d = hbc_q + 3'd1;
				end
			end
			wsfpe_pkg::PH_KEY: begin
				key_d[{hbc_q[1:0], 3'b000} +: 8] = frame_byte;
				if (hbc_q >= 3'd3) begin
					hbc_d   = 3'd0;
					midx_d  = 2'd0;
					phase_d = (rem_q != '0) ? wsfpe_pkg::PH_PAY : wsfpe_pkg::PH_TRAIL;
				end else begin
					hbc_d = hbc_q + 3'd1;
				end
			end
			wsfpe_pkg::PH_PAY: begin
				pb     = frame_byte ^ (masked_q ? key_q[{midx_q, 3'b000} +: 8] : 8'd0);
				midx_d = midx_q + 2'd1;
				has    = 1'b1;
				rem_d  = rem_q - {{(LB-1){1'b0}}, 1'b1};
				if (rem_q == {{(LB-1){1'b0}}, 1'b1}) begin
					phase_d = wsfpe_pkg::PH_TRAIL;
				end
			end
			default: begin
			end
		endcase

		// Header done: key next, or straight to payload
		if (go_after) begin
			rem_d = after_len;
			hbc_d = 3'd0;
			if (after_masked) begin
				key_d   = 32'd0;
				phase_d = wsfpe_pkg::PH_KEY;
			end else begin
				midx_d  = 2'd0;
				phase_d = (after_len != '0) ? wsfpe_pkg::PH_PAY : wsfpe_pkg::PH_TRAIL;
			end
		end
	end

	always_comb begin
		result.emit         = frame_end | has;
		result.payload_byte = pb;
		result.has_byte     = has;
		result.end_of_frame = frame_end;
		result.status       = frame_end & (phase_d != wsfpe_pkg::PH_TRAIL);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= wsfpe_pkg::PH_FIRST;
			rem_q    <= '0;
			hbc_q    <= 3'd0;
			key_q    <= 32'd0;
			midx_q   <= 2'd0;
			masked_q <= 1'b0;
		end else if (step) begin
			if (frame_end) begin
				phase_q  <= wsfpe_pkg::PH_FIRST;
				rem_q    <= '0;
				hbc_q    <= 3'd0;
				key_q    <= 32'd0;
				midx_q   <= 2'd0;
				masked_q <= 1'b0;
			end else begin
				phase_q  <= phase_d;
				rem_q    <= rem_d;
				hbc_q    <= hbc_d;
				key_q    <= key_d;
				midx_q   <= midx_d;
				masked_q <= masked_d;
			end
		end
	end

`ifndef SYNTHESIS
	// Frame close returns the parser to the idle header state
	a_close_resets: assert property (@(posedge clk) disable iff (!arst_n)
		step && frame_end |=> phase_q == wsfpe_pkg::PH_FIRST && rem_q == '0)
		else $error("parser state not cleared after frame close");

	// Payload phase always has bytes left to deliver
	a_pay_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == wsfpe_pkg::PH_PAY |-> rem_q != '0)
		else $error("payload phase with zero remaining length");

	// 16-bit extended length takes two bytes only
	a_ext16_count: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == wsfpe_pkg::PH_EXT16 |-> hbc_q <= 3'd1)
		else $error("16-bit length byte count out of range");
`endif

endmodule

// ===== design/wsfpe_result_reg.sv =====
// ----------------------------------------------------------------------------
// wsfpe_result_reg
// Output register for results; reports whether it can take a new one.
// ----------------------------------------------------------------------------
module wsfpe_result_reg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  wsfpe_pkg::result_t  result,
	output logic                room,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [7:0]          payload_byte,
	output logic                has_byte,
	output logic                end_of_frame,
	output logic                status
);

	logic       valid_q;
	logic [7:0] byte_q;
	logic       has_q;
	logic       eof_q;
	logic       status_q;

	assign room = !valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (room) begin
			valid_q <= load && result.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (room && load && result.emit) begin
			byte_q   <= result.payload_byte;
			has_q    <= result.has_byte;
			eof_q    <= result.end_of_frame;
			status_q <= result.status;
		end
	end

	assign out_valid    = valid_q;
	assign payload_byte = byte_q;
	assign has_byte     = has_q;
	assign end_of_frame = eof_q;
	assign status       = status_q;

endmodule

// ===== design/websocket_frame_payload_extractor.sv =====
// ----------------------------------------------------------------------------
// websocket_frame_payload_extractor
// Parses a WebSocket frame byte stream and emits unmasked payload bytes.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+---------------------------------------------
//  in      | in_valid / in_stall  | frame_byte, frame_end
//  out     | out_valid / out_stall| payload_byte, has_byte, end_of_frame, status
//
//  One frame byte per cycle unless the output stalls; bytes pass the input
//  register, then result register; the single step between sets the rate.
//  Reset (arst_n low) empties both registers and returns to the header start.
//  A stalled output blocks the input only while both registers are full.
//  Header bytes and trailing bytes make no transaction; the frame's last byte
//  always makes exactly one transaction with end_of_frame set.
// ----------------------------------------------------------------------------
module websocket_frame_payload_extractor (
	input  logic       clk,
	input  logic       arst_n,
	// input channel
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] frame_byte,
	input  logic       frame_end,
	// output channel
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] payload_byte,
	output logic       has_byte,
	output logic       end_of_frame,
	output logic       status
);

	logic               valid_s1;
	logic [7:0]         byte_s1;
	logic               end_s1;
	logic               room;
	logic               advance;
	logic               take;
	wsfpe_pkg::result_t result;

	// Input stage moves on whenever the result register has room
	assign advance  = valid_s1 && room;
	assign in_stall = valid_s1 && !room;
	assign take     = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			byte_s1 <= frame_byte;
			end_s1  <= frame_end;
		end
	end

	// Header decode, key capture, unmasking and length tracking
	wsfpe_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (advance),
		.frame_byte (byte_s1),
		.frame_end  (end_s1),
		.result     (result)
	);

	wsfpe_result_reg u_result (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (advance),
		.result       (result),
		.room         (room),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.payload_byte (payload_byte),
		.has_byte     (has_byte),
		.end_of_frame (end_of_frame),
		.status       (status)
	);

`ifndef SYNTHESIS
	// A transaction that does not close a frame must carry a byte
	a_no_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !end_of_frame |-> has_byte)
		else $error("result without byte and without end of frame");

	// Truncation is reported only on the closing transaction
	a_status_on_close: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status |-> end_of_frame)
		else $error("status set on a non-closing result");

	// A stalled output transaction holds still
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(payload_byte) &&
		$stable(has_byte) && $stable(end_of_frame) && $stable(status))
		else $error("stalled output transaction changed");
`endif

endmodule

// ===== tb/tb_websocket_frame_payload_extractor.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_websocket_frame_payload_extractor
// Self-checking bench for the frame payload extractor. Frames are fed a byte
// per transaction, and a byte-level parser model predicts every output
// transaction (payload byte, closing flag, truncation status). The output
// transactions are checked in order. Directed frames cover the header forms
// and corner cases. Random frames follow, plus a long output hold-off and a
// stretch with no idling on either side.
// ----------------------------------------------------------------------------
module tb_websocket_frame_payload_extractor;

	localparam int CLK_HALF     = 4;
	localparam int RESET_CYCLES = 7;
	localparam int CYCLE_LIMIT  = 100000;
	localparam int DRAIN_CYCLES = 8;     // covers the input and result registers
	localparam int MAX_REPORTS  = 10;
	localparam int LB           = wsfpe_pkg::LENGTH_BITS;

	localparam logic [LB-1:0] LEN_MAX = '1;

	// How the payload length is encoded in the header
	typedef enum int {LEN_SHORT, LEN_EXT16, LEN_EXT64} len_form_t;

	// One output transaction
	typedef struct packed {
		logic [7:0] payload_byte;
		logic       has_byte;
		logic       end_of_frame;
		logic       status;
	} frame_result_t;

	logic       clk        = 1'b0;
	logic       arst_n     = 1'b0;
	logic       in_valid   = 1'b0;
	logic       in_stall;
	logic [7:0] frame_byte = 8'h00;
	logic       frame_end  = 1'b0;
	logic       out_valid;
	logic       out_stall  = 1'b0;
	logic [7:0] payload_byte;
	logic       has_byte;
	logic       end_of_frame;
	logic       status;

	websocket_frame_payload_extractor dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.frame_byte   (frame_byte),
		.frame_end    (frame_end),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.payload_byte (payload_byte),
		.has_byte     (has_byte),
		.end_of_frame (end_of_frame),
		.status       (status)
	);

	always #CLK_HALF clk = ~clk;

	// Parser model state
	logic [wsfpe_pkg::PHASE_W-1:0] ps_phase;
	logic [LB-1:0]                 ps_remaining;
	logic [2:0]                    ps_hdr_count;
	logic [31:0]                   ps_key;
	logic [1:0]                    ps_key_idx;
	logic                          ps_masked;

	frame_result_t pending_results[$];   // predicted, not yet seen on the output
	logic [7:0]    frame_buf[$];         // frame under construction
	int            mismatch_count  = 0;
	bit            tx_no_idle      = 1'b0;
	bit            rx_no_idle      = 1'b0;
	int            rx_hold_request = 0;  // long output hold-off, in cycles

	function automatic void expect_result(input frame_result_t r);
		pending_results = {pending_results, r};
	endfunction

	function automatic void add_frame_byte(input logic [7:0] b);
		frame_buf = {frame_buf, b};
	endfunction

	// ------------------------------------------------------------------------
	// Parser model
	// ------------------------------------------------------------------------
	function automatic void clear_parser();
		ps_phase     = wsfpe_pkg::PH_FIRST;
		ps_remaining = '0;
		ps_hdr_count = '0;
		ps_key       = '0;
		ps_key_idx   = '0;
		ps_masked    = 1'b0;
	endfunction

	function automatic void enter_payload();
		ps_key_idx = '0;
		ps_phase   = (ps_remaining != 0) ? wsfpe_pkg::PH_PAY : wsfpe_pkg::PH_TRAIL;
	endfunction

	// Length fully known: the key follows only on masked frames
	function automatic void enter_key_or_payload();
		ps_hdr_count = '0;
		if (ps_masked) begin
			ps_key   = '0;
			ps_phase = wsfpe_pkg::PH_KEY;
		end else begin
			enter_payload();
		end
	endfunction

	// Advance the model by one accepted byte and queue what it must produce
	function automatic void parse_frame_byte(input logic [7:0] b, input logic is_last);
		logic [7:0] pb;
		logic       has;
		int         need;
		pb  = 8'h00;
		has = 1'b0;
		case (ps_phase)
			wsfpe_pkg::PH_FIRST: begin
				ps_phase = wsfpe_pkg::PH_LEN;   // opcode byte carries nothing we use
			end
			wsfpe_pkg::PH_LEN: begin
				ps_masked    = b[7];
				ps_remaining = '0;
				ps_hdr_count = '0;
				if (b[6:0] == wsfpe_pkg::LEN_CODE_EXT16) begin
					ps_phase = wsfpe_pkg::PH_EXT16;
				end else if (b[6:0] == wsfpe_pkg::LEN_CODE_EXT64) begin
					ps_phase = wsfpe_pkg::PH_EXT64;
				end else begin
					ps_remaining = LB'(b[6:0]);
					enter_key_or_payload();
				end
			end
			wsfpe_pkg::PH_EXT16, wsfpe_pkg::PH_EXT64: begin
				need = (ps_phase == wsfpe_pkg::PH_EXT16) ? 2 : 8;
				// big-endian accumulate; saturate when the next shift would overflow
				if (ps_remaining > (LEN_MAX >> 8))
					ps_remaining = LEN_MAX;
				else
					ps_remaining = {ps_remaining[LB-9:0], b};
				if (ps_hdr_count + 1 >= need)
					enter_key_or_payload();
				else
					ps_hdr_count = ps_hdr_count + 1'b1;
			end
			wsfpe_pkg::PH_KEY: begin
				ps_key = ps_key | (32'(b) << (8 * ps_hdr_count[1:0]));
				if (ps_hdr_count >= 3) begin
					ps_hdr_count = '0;
					enter_payload();
				end else begin
					ps_hdr_count = ps_hdr_count + 1'b1;
				end
			end
			wsfpe_pkg::PH_PAY: begin
				pb           = ps_masked ? (b ^ ps_key[8*ps_key_idx +: 8]) : b;
				ps_key_idx   = ps_key_idx + 1'b1;
				has          = 1'b1;
				ps_remaining = ps_remaining - 1'b1;
				if (ps_remaining == 0)
					ps_phase = wsfpe_pkg::PH_TRAIL;
			end
			default: begin
			end
		endcase
		if (is_last) begin
			// closing transaction; anything short of the trailer is a truncation
			expect_result('{pb, has, 1'b1, ps_phase != wsfpe_pkg::PH_TRAIL});
			clear_parser();
		end else if (has) begin
			expect_result('{pb, 1'b1, 1'b0, 1'b0});
		end
	endfunction

	// ------------------------------------------------------------------------
	// Input side
	// ------------------------------------------------------------------------
	task automatic send_frame_byte(input logic [7:0] b, input logic is_last);
		if (!tx_no_idle && $urandom_range(99) < 8) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid   <= 1'b1;
		frame_byte <= b;
		frame_end  <= is_last;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		parse_frame_byte(b, is_last);
	endtask

	// Whole buffer goes out, end flag on its final byte
	task automatic send_frame();
		foreach (frame_buf[i])
			send_frame_byte(frame_buf[i], i == frame_buf.size() - 1);
	endtask

	// Header with the given encoding, random opcode byte and key, body_bytes of
	// random payload. A body shorter than the length gives a truncated frame.
	task automatic build_frame(input logic masked, input len_form_t form,
			input logic [63:0] len, input int body_bytes);
		int ext_bytes;
		frame_buf.delete();
		add_frame_byte(8'($urandom));
		case (form)
			LEN_SHORT: begin
				add_frame_byte({masked, len[6:0]});
				ext_bytes = 0;
			end
			LEN_EXT16: begin
				add_frame_byte({masked, wsfpe_pkg::LEN_CODE_EXT16});
				ext_bytes = 2;
			end
			default: begin
				add_frame_byte({masked, wsfpe_pkg::LEN_CODE_EXT64});
				ext_bytes = 8;
			end
		endcase
		for (int i = ext_bytes - 1; i >= 0; i--)
			add_frame_byte(len[8*i +: 8]);
		if (masked)
			repeat (4) add_frame_byte(8'($urandom));
		repeat (body_bytes) add_frame_byte(8'($urandom));
	endtask

	// Mostly well-formed frames, with trailers, cut-offs and plain noise mixed in
	task automatic send_random_frames(input int n_bytes);
		int          sent;
		int          pick;
		int          cut;
		logic [63:0] len;
		len_form_t   form;
		sent = 0;
		while (sent < n_bytes) begin
			pick = $urandom_range(9);
			if (pick <= 5) begin
				form = LEN_SHORT;
				len  = ($urandom_range(9) == 0) ? 64'($urandom_range(125)) :
					64'($urandom_range(12));
			end else if (pick <= 7) begin
				form = LEN_EXT16;
				len  = ($urandom_range(3) == 0) ? 64'($urandom_range(65535)) :
					64'($urandom_range(40));
			end else begin
				form = LEN_EXT64;
				len  = ($urandom_range(3) == 0) ? {$urandom, $urandom} :
					64'($urandom_range(40));
			end
			// long payloads are never sent whole, they end up truncated
			build_frame(1'($urandom_range(1)), form, len,
				(len > 40) ? int'($urandom_range(40)) : int'(len));
			pick = $urandom_range(99);
			if (pick < 10) begin
				repeat ($urandom_range(1, 4)) add_frame_byte(8'($urandom));
			end else if (pick < 25) begin
				cut = $urandom_range(1, frame_buf.size());
				while (frame_buf.size() > cut)
					void'(frame_buf.pop_back());
			end else if (pick < 30) begin
				frame_buf.delete();
				repeat ($urandom_range(1, 10)) add_frame_byte(8'($urandom));
			end
			send_frame();
			sent += frame_buf.size();
		end
	endtask

	// ------------------------------------------------------------------------
	// Output side: random stall, plus the long hold-off on request
	// ------------------------------------------------------------------------
	initial begin
		int hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (rx_hold_request != 0) begin
				hold_left       = rx_hold_request;
				rx_hold_request = 0;
			end
			if (hold_left != 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= !rx_no_idle && ($urandom_range(99) < 8);
			end
		end
	end

	// ------------------------------------------------------------------------
	// Result checking: each output transaction against the oldest prediction
	// ------------------------------------------------------------------------
	function automatic void report_mismatch(input string what, input frame_result_t exp_r,
			input frame_result_t got_r);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS) begin
			$write("%0t ERROR %s: expected byte=%02h has=%0b eof=%0b st=%0b, ",
				$time, what, exp_r.payload_byte, exp_r.has_byte, exp_r.end_of_frame,
				exp_r.status);
			$display("got byte=%02h has=%0b eof=%0b st=%0b",
				got_r.payload_byte, got_r.has_byte, got_r.end_of_frame, got_r.status);
		end
	endfunction

	always @(posedge clk) begin
		frame_result_t got_r;
		frame_result_t exp_r;
		if (arst_n && out_valid && !out_stall) begin
			got_r = '{payload_byte, has_byte, end_of_frame, status};
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected transaction", 'x, got_r);
			end else begin
				exp_r = pending_results.pop_front();
				if (got_r.payload_byte !== exp_r.payload_byte ||
						got_r.has_byte !== exp_r.has_byte ||
						got_r.end_of_frame !== exp_r.end_of_frame ||
						got_r.status !== exp_r.status)
					report_mismatch("result mismatch", exp_r, got_r);
			end
		end
	end

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// Header forms and corner cases, one short frame each
	task automatic test_directed_frames();
		// short length 1: payload 00, then a trailing byte closes it cleanly
		frame_buf = {8'hFF, 8'h01, 8'h00, 8'hFF};
		send_frame();
		// masked, zero length: complete right after the last key byte
		frame_buf = {8'h00, 8'h80, 8'h11, 8'h22, 8'h33, 8'h44};
		send_frame();
		// 16-bit length of 1; the payload byte is also the last byte
		frame_buf = {8'h00, 8'h7E, 8'h00, 8'h01, 8'hFF};
		send_frame();
		// masked 64-bit all-ones length saturates; ends before the key arrives
		frame_buf = {8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
			8'hFF, 8'hFF, 8'hFF, 8'hFF};
		send_frame();
		// lone first byte: truncated header
		frame_buf = {8'h00};
		send_frame();
	endtask

	task automatic test_random_frames();
		send_random_frames(300);
	endtask

	// Hold the output long enough that both stages fill and the input stalls
	task automatic test_backpressure();
		build_frame(1'b1, LEN_SHORT, 64'd50, 50);
		tx_no_idle      = 1'b1;
		rx_hold_request = 150;
		send_frame();
		tx_no_idle = 1'b0;
	endtask

	// Back-to-back transactions with neither side idling
	task automatic test_streaming_no_idle();
		tx_no_idle = 1'b1;
		rx_no_idle = 1'b1;
		send_random_frames(100);
		tx_no_idle = 1'b0;
		rx_no_idle = 1'b0;
	endtask

	// Watchdog
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		clear_parser();
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_frames();
		test_random_frames();
		test_backpressure();
		test_streaming_no_idle();
		in_valid <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		while (pending_results.size() != 0)
			report_mismatch("missing transaction", pending_results.pop_front(), 'x);

		if (mismatch_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
